// File: sv/assert_macros.svh
// Assertion macros used by the datapath RTL of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/dqvs_pkg.sv
// Shared types, constants and ring-index helpers of the deque with value search.
package dqvs_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int REQ_W     = 3;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int POS_W     = 4;
  localparam int CNTO_W    = 5;
  localparam int POS_XW    = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int CNT_XW    = (CNT_W > CNTO_W) ? CNT_W : CNTO_W;
  localparam int MDATA_W   = ((VAL_W + POS_W + CNTO_W + 7) / 8) * 8;
  localparam int MPAD_W    = MDATA_W - (VAL_W + POS_W + CNTO_W);

  // popped value reported for an empty queue
  localparam logic [VAL_W-1:0] EMPTY_MARK = 32'hFFFF_D8F1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_TAIL = 3'd0,
    REQ_PUSH_HEAD = 3'd1,
    REQ_POP_HEAD  = 3'd2,
    REQ_POP_TAIL  = 3'd3,
    REQ_FIND      = 3'd4
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // latch the input beat
    logic exec;      // run the request against the ring
    logic rd_done;   // pop read data is valid
    logic scan;      // one search step
    logic load_out;  // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t req;
    logic empty;
    logic hit;
    logic scan_end;
    logic out_free;
  } sts_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    ring_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

endpackage

// File: sv/dqvs_ctrl.sv
// Request sequencer of the deque: steps each beat through execute, a read or scan step where needed, and output.
module dqvs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  dqvs_pkg::sts_t sts,
  output dqvs_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (sts.req)
          dqvs_pkg::REQ_POP_HEAD, dqvs_pkg::REQ_POP_TAIL: begin
            state_next = sts.empty ? S_DONE : S_RDWAIT;
          end
          dqvs_pkg::REQ_FIND: begin
            state_next = sts.empty ? S_DONE : S_SCAN;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RDWAIT: state_next = S_DONE;
      S_SCAN: begin
        if (sts.hit || sts.scan_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands decoded from state
  always_comb begin
    s_tready     = (state == S_IDLE);
    cmd.take     = (state == S_IDLE) && s_tvalid;
    cmd.exec     = (state == S_EXEC);
    cmd.rd_done  = (state == S_RDWAIT);
    cmd.scan     = (state == S_SCAN);
    cmd.load_out = (state == S_DONE) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/dqvs_datapath.sv
// Ring store, head/tail/count registers, search compare and output register of the deque.
`include "assert_macros.svh"

module dqvs_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dqvs_pkg::cmd_t                       cmd,
  output dqvs_pkg::sts_t                       sts,
  input  logic [dqvs_pkg::VAL_W-1:0]           s_tdata,
  input  logic [dqvs_pkg::REQ_W-1:0]           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [dqvs_pkg::MDATA_W-1:0]         m_tdata,
  output logic [dqvs_pkg::ST_W-1:0]            m_tuser
);

  // request latch
  dqvs_pkg::req_t                  req_q;
  logic [dqvs_pkg::VAL_W-1:0]      val_q;

  // ring state
  logic [dqvs_pkg::VAL_W-1:0]      mem [dqvs_pkg::DEPTH];
  logic [dqvs_pkg::VAL_W-1:0]      rd_data;
  logic [dqvs_pkg::IDX_W-1:0]      head;
  logic [dqvs_pkg::IDX_W-1:0]      tail;
  logic [dqvs_pkg::CNT_W-1:0]      count;

  // search state
  logic [dqvs_pkg::IDX_W-1:0]      k;
  logic [dqvs_pkg::IDX_W-1:0]      slot;

  // result and output register
  dqvs_pkg::status_t               res_status;
  logic [dqvs_pkg::VAL_W-1:0]      res_value;
  logic [dqvs_pkg::IDX_W-1:0]      res_pos;
  logic [dqvs_pkg::ST_W-1:0]       out_status;
  logic [dqvs_pkg::VAL_W-1:0]      out_value;
  logic [dqvs_pkg::POS_W-1:0]      out_pos;
  logic [dqvs_pkg::CNTO_W-1:0]     out_count;

  logic                            full;
  logic                            empty;
  logic                            hit;
  logic                            scan_end;
  logic                            mem_we;
  logic                            mem_re;
  logic [dqvs_pkg::IDX_W-1:0]      wr_addr;
  logic [dqvs_pkg::IDX_W-1:0]      rd_addr;
  logic [dqvs_pkg::POS_XW-1:0]     pos_x;
  logic [dqvs_pkg::CNT_XW-1:0]     cnt_x;

  assign full     = (count == dqvs_pkg::CNT_W'(dqvs_pkg::DEPTH));
  assign empty    = (count == '0);
  assign hit      = (rd_data == val_q);
  assign scan_end = ((dqvs_pkg::CNT_W'(k) + 1'b1) == count);

  assign sts.req      = req_q;
  assign sts.empty    = empty;
  assign sts.hit      = hit;
  assign sts.scan_end = scan_end;
  assign sts.out_free = !m_tvalid || m_tready;

  // single write and single read port address select
  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    wr_addr = tail;
    rd_addr = head;
    if (cmd.exec) begin
      case (req_q)
        dqvs_pkg::REQ_PUSH_TAIL: begin
          mem_we  = !full;
          wr_addr = tail;
        end
        dqvs_pkg::REQ_PUSH_HEAD: begin
          mem_we  = !full;
          wr_addr = dqvs_pkg::ring_prev(head);
        end
        dqvs_pkg::REQ_POP_HEAD: begin
          mem_re  = !empty;
          rd_addr = head;
        end
        dqvs_pkg::REQ_POP_TAIL: begin
          mem_re  = !empty;
          rd_addr = dqvs_pkg::ring_prev(tail);
        end
        dqvs_pkg::REQ_FIND: begin
          mem_re  = !empty;
          rd_addr = head;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end else if (cmd.scan) begin
      mem_re  = !hit && !scan_end;
      rd_addr = slot;
    end
  end

  // ring store
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= val_q;
    if (mem_re) rd_data <= mem[rd_addr];
  end

  // request latch, pointers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.take) begin
        req_q <= dqvs_pkg::req_t'(s_tuser);
        val_q <= s_tdata;
      end
      if (cmd.exec) begin
        res_status <= dqvs_pkg::ST_OK;
        res_value  <= '0;
        res_pos    <= '0;
        case (req_q)
          dqvs_pkg::REQ_PUSH_TAIL: begin
            if (full) begin
              res_status <= dqvs_pkg::ST_FULL;
            end else begin
              tail  <= dqvs_pkg::ring_next(tail);
              count <= count + 1'b1;
            end
          end
          dqvs_pkg::REQ_PUSH_HEAD: begin
            if (full) begin
              res_status <= dqvs_pkg::ST_FULL;
            end else begin
              head  <= dqvs_pkg::ring_prev(head);
              count <= count + 1'b1;
            end
          end
          dqvs_pkg::REQ_POP_HEAD: begin
            if (empty) begin
              res_status <= dqvs_pkg::ST_EMPTY;
              res_value  <= dqvs_pkg::EMPTY_MARK;
            end else begin
              head  <= dqvs_pkg::ring_next(head);
              count <= count - 1'b1;
            end
          end
          dqvs_pkg::REQ_POP_TAIL: begin
            if (empty) begin
              res_status <= dqvs_pkg::ST_EMPTY;
              res_value  <= dqvs_pkg::EMPTY_MARK;
            end else begin
              tail  <= dqvs_pkg::ring_prev(tail);
              count <= count - 1'b1;
            end
          end
          dqvs_pkg::REQ_FIND: begin
            res_status <= dqvs_pkg::ST_NOTFOUND;
            k          <= '0;
            slot       <= dqvs_pkg::ring_next(head);
          end
          default: begin
            res_status <= dqvs_pkg::ST_OK;
          end
        endcase
      end
      // pop data returns in the cycle after the read
      if (cmd.rd_done) res_value <= rd_data;
      // search: compare entry k, else fetch the next slot
      if (cmd.scan) begin
        if (hit) begin
          res_status <= dqvs_pkg::ST_OK;
          res_pos    <= k;
        end else if (!scan_end) begin
          k    <= k + 1'b1;
          slot <= dqvs_pkg::ring_next(slot);
        end
      end
    end
  end

  // output register, masked to field widths
  assign pos_x = dqvs_pkg::POS_XW'(res_pos);
  assign cnt_x = dqvs_pkg::CNT_XW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        m_tvalid   <= 1'b1;
        out_status <= res_status;
        out_value  <= res_value;
        out_pos    <= pos_x[dqvs_pkg::POS_W-1:0];
        out_count  <= cnt_x[dqvs_pkg::CNTO_W-1:0];
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{dqvs_pkg::MPAD_W{1'b0}}, out_count, out_pos, out_value};
  assign m_tuser = out_status;

  `ASSERT_IMPL(a_count_max, 1'b1, count <= dqvs_pkg::CNT_W'(dqvs_pkg::DEPTH), "count above depth")
  `ASSERT_IMPL(a_ring_wrap, (empty || full), head == tail, "head and tail differ when empty or full")
  `ASSERT_IMPL(a_scan_range, cmd.scan, dqvs_pkg::CNT_W'(k) < count, "search index past count")
  `ASSERT_IMPL(a_load_free, cmd.load_out, (!m_tvalid || m_tready), "result overwrites waiting beat")

endmodule

// File: sv/deque_with_value_search_top.sv
// Top level of the bounded double-ended queue with value search.
// One request at a time: a push runs execute then output, a pop adds a read step
// between them, and a find adds a search that the single read port of the ring store
// paces, walking one entry per cycle from the head. A new request is accepted while
// the previous result still waits in the output register. s_tuser carries the request
// type, m_tuser the status.
module deque_with_value_search_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dqvs_pkg::VAL_W-1:0]    s_tdata,   // [31:0] value_in
  input  logic [dqvs_pkg::REQ_W-1:0]    s_tuser,   // [2:0] req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dqvs_pkg::MDATA_W-1:0]  m_tdata,   // [31:0] value_out, [35:32] position,
                                                   // [40:36] count_out, rest zero
  output logic [dqvs_pkg::ST_W-1:0]     m_tuser    // [1:0] status
);

  dqvs_pkg::cmd_t cmd;
  dqvs_pkg::sts_t sts;

  dqvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dqvs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: tb/sv/tb_deque_with_value_search_top.sv
// Self-checking testbench for the deque with value search: directed and random stream traffic vs. a ring model.
`timescale 1ns / 100ps

module tb_deque_with_value_search_top;
  import dqvs_pkg::*;

  // result beat layout, lowest field first
  localparam int POS_LSB   = VAL_W;
  localparam int CNT_LSB   = VAL_W + POS_W;
  localparam int PAD_LSB   = VAL_W + POS_W + CNTO_W;
  localparam int HOLD_OFF  = 300;   // long receiver hold-off, in cycles
  localparam int IDLE_MAX  = 4000;  // cycles without any beat before giving up
  localparam int TAIL_WAIT = 25;    // settle time after the last reply
  localparam int RAND_ITEMS = 1535;
  localparam int PRINT_MAX = 50;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    logic [CNTO_W-1:0] count;
  } deque_reply_t;

  // Ring model of the deque plus the queue of predicted replies
  class deque_tracker;
    logic [VAL_W-1:0] ring [DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned count;
    deque_reply_t reply_q[$];
    int unsigned mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      head = 0;
      tail = 0;
      count = 0;
      mismatches = 0;
    endfunction

    function int unsigned step_fwd(int unsigned i);
      return (i == DEPTH - 1) ? 0 : i + 1;
    endfunction

    function int unsigned step_back(int unsigned i);
      return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function int unsigned pending();
      return reply_q.size();
    endfunction

    // k-th entry counted from the head
    function logic [VAL_W-1:0] held_value(int unsigned k);
      return ring[(head + k) % DEPTH];
    endfunction

    // Apply one accepted request beat and queue the reply it must produce
    function void note_request(logic [REQ_W-1:0] req_bits, logic [VAL_W-1:0] val);
      deque_reply_t r;
      int unsigned slot;
      r.status = ST_OK;
      r.value = '0;
      r.position = '0;
      case (req_bits)
        REQ_PUSH_TAIL: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            ring[tail] = val;
            tail = step_fwd(tail);
            count++;
          end
        end
        REQ_PUSH_HEAD: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            head = step_back(head);
            ring[head] = val;
            count++;
          end
        end
        REQ_POP_HEAD: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
            r.value = EMPTY_MARK;
          end else begin
            r.value = ring[head];
            head = step_fwd(head);
            count--;
          end
        end
        REQ_POP_TAIL: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
            r.value = EMPTY_MARK;
          end else begin
            tail = step_back(tail);
            r.value = ring[tail];
            count--;
          end
        end
        REQ_FIND: begin
          // first match wins, scanning from the head
          r.status = ST_NOTFOUND;
          slot = head;
          for (int k = 0; k < count; k++) begin
            if (ring[slot] == val) begin
              r.status = ST_OK;
              r.position = POS_W'(k);
              break;
            end
            slot = step_fwd(slot);
          end
        end
        default: ;
      endcase
      r.count = CNTO_W'(count);
      reply_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_MAX) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Compare one accepted reply beat with the oldest prediction
    task check_reply(logic [ST_W-1:0] st, logic [MDATA_W-1:0] data);
      deque_reply_t want;
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("reply with nothing pending: status %0d data %h", st, data));
        return;
      end
      want = reply_q.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (data[VAL_W-1:0] !== want.value)
        report_mismatch($sformatf("value %h, want %h", data[VAL_W-1:0], want.value));
      if (data[CNT_LSB-1:POS_LSB] !== want.position)
        report_mismatch($sformatf("position %0d, want %0d",
                                  data[CNT_LSB-1:POS_LSB], want.position));
      if (data[PAD_LSB-1:CNT_LSB] !== want.count)
        report_mismatch($sformatf("count %0d, want %0d", data[PAD_LSB-1:CNT_LSB], want.count));
      if (data[MDATA_W-1:PAD_LSB] !== '0)
        report_mismatch($sformatf("pad bits %h not zero", data[MDATA_W-1:PAD_LSB]));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [VAL_W-1:0]   s_tdata;   // [31:0] value_in
  logic [REQ_W-1:0]   s_tuser;   // [2:0] req_type
  logic               m_tvalid;
  logic               m_tready;
  logic [MDATA_W-1:0] m_tdata;   // [31:0] value_out, [35:32] position, [40:36] count_out
  logic [ST_W-1:0]    m_tuser;   // [1:0] status

  deque_tracker sb = new();
  bit          tx_stall_on = 1'b0;
  bit          rx_stall_on = 1'b0;
  bit          hold_off_go = 1'b0;
  int unsigned idle_cycles = 0;

  deque_with_value_search_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return $urandom_range(15, 50);
    if (r < 30) return $urandom_range(1, 3);
    return 0;
  endfunction

  // small pool so finds hit and duplicates show up, plus full-range noise
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 45) return $urandom;
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return EMPTY_MARK;
      5: return 32'd1;
      6: return 32'd42;
      default: return 32'd7;
    endcase
  endfunction

  // Beat monitor: predict on accepted requests, check accepted replies
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_reply(m_tuser, m_tdata);
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: always ready, random back-pressure, or one long hold-off on request
  initial begin
    int unsigned gap;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_off_go) begin
        hold_off_go = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF - 1) @(negedge clk);
      end else if (rx_stall_on) begin
        gap = pick_gap();
        if (gap == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one request beat and hold it until accepted; valid stays high afterwards
  task automatic send_request(input req_t req, input logic [VAL_W-1:0] val);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_sender(input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted reply has come back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random request; mix biases the deque toward full or empty
  task automatic next_request(input mix_t mix, output req_t req, output logic [VAL_W-1:0] val);
    int unsigned r;
    int unsigned p_tail, p_head, p_pop_h, p_pop_t;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin p_tail = 35; p_head = 70; p_pop_h = 78; p_pop_t = 86; end
      MIX_DRAIN: begin p_tail = 10; p_head = 20; p_pop_h = 50; p_pop_t = 80; end
      default:   begin p_tail = 20; p_head = 40; p_pop_h = 60; p_pop_t = 80; end
    endcase
    if (r < p_tail) req = REQ_PUSH_TAIL;
    else if (r < p_head) req = REQ_PUSH_HEAD;
    else if (r < p_pop_h) req = REQ_POP_HEAD;
    else if (r < p_pop_t) req = REQ_POP_TAIL;
    else req = REQ_FIND;
    // finds mostly look for something held
    if (req == REQ_FIND && sb.count != 0 && $urandom_range(0, 9) < 6)
      val = sb.held_value($urandom_range(0, sb.count - 1));
    else
      val = pick_value();
  endtask

  // Main sequence
  initial begin
    req_t             req;
    logic [VAL_W-1:0] val;
    mix_t             mix;
    int unsigned      n;
    int unsigned      sent;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_PUSH_TAIL;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty cases, extremes, find at both ends and a miss, drain
    send_request(REQ_POP_HEAD, 32'd5);
    send_request(REQ_POP_TAIL, 32'd5);
    send_request(REQ_FIND, 32'd0);
    send_request(REQ_PUSH_TAIL, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_HEAD, 32'h8000_0000);
    send_request(REQ_PUSH_TAIL, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_HEAD, 32'h0000_0000);
    send_request(REQ_FIND, 32'hFFFF_FFFF);
    send_request(REQ_FIND, 32'h0000_0000);
    send_request(REQ_FIND, 32'd5);
    send_request(REQ_POP_HEAD, 32'd0);
    send_request(REQ_POP_TAIL, 32'd0);
    send_request(REQ_POP_HEAD, 32'd0);
    send_request(REQ_POP_TAIL, 32'd0);
    send_request(REQ_POP_TAIL, 32'd0);
    wait_drained();

    // long receiver hold-off while requests keep coming: input must stall
    sent = 0;
    hold_off_go = 1'b1;
    repeat (40) begin
      next_request(MIX_FILL, req, val);
      send_request(req, val);
      sent++;
    end
    wait_drained();

    // random phases with random idling on each side
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 2))
        0: mix = MIX_FILL;
        1: mix = MIX_DRAIN;
        default: mix = MIX_BALANCED;
      endcase
      tx_stall_on = ($urandom_range(0, 9) < 7);
      rx_stall_on = ($urandom_range(0, 9) < 7);
      n = $urandom_range(50, 120);
      repeat (n) begin
        next_request(mix, req, val);
        if (tx_stall_on) idle_sender(pick_gap());
        send_request(req, val);
        sent++;
      end
      wait_drained();
    end

    rx_stall_on = 1'b0;
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch($sformatf("%0d replies never came", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
